FILE: src/rmf_pkg.sv
`timescale 1ns / 1ps

package rmf_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int WINDOW_MAX   = 16;
    localparam int IDX_W        = $clog2(WINDOW_MAX);
    localparam int RANK_W       = IDX_W;
    localparam int ORDER_W      = 5;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [IDX_W-1:0]               idx_t;
    typedef logic [RANK_W-1:0]              rank_t;
    typedef logic [ORDER_W-1:0]             order_t;

    localparam order_t ORDER_MIN   = order_t'(2);
    localparam order_t ORDER_MAX   = order_t'(WINDOW_MAX);
    localparam order_t ORDER_RESET = order_t'(16);

    // A sample travelling round the ring of cells, tagged with its window position.
    typedef struct packed {
        sample_t value;
        idx_t    idx;
    } link_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic load;
        logic start;
        logic step;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

FILE: src/rmf_if.sv
`timescale 1ns / 1ps

interface rmf_in_if;
    import rmf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;
    logic    start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface rmf_out_if;
    import rmf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

FILE: src/rmf_cell.sv
`timescale 1ns / 1ps

module rmf_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  rmf_pkg::cell_ctrl_t ctrl,
    input  rmf_pkg::idx_t      pos,
    input  rmf_pkg::order_t    order,
    input  rmf_pkg::sample_t   shift_in,
    input  rmf_pkg::link_t     link_in,
    output rmf_pkg::sample_t   value,
    output rmf_pkg::link_t     link_out,
    output rmf_pkg::rank_t     rank,
    output logic               in_win
);
    import rmf_pkg::*;

    sample_t value_reg, value_next;
    link_t   link_reg, link_next;
    rank_t   rank_reg, rank_next;
    logic    head;
    logic    link_in_win;
    logic    below;

    assign head        = (pos == idx_t'(0));
    assign in_win      = (order_t'(pos) < order);
    assign link_in_win = (order_t'(link_reg.idx) < order);

    // Strict order with ties broken by position, so every entry gets a distinct rank.
    assign below = (link_reg.value < value_reg)
                || ((link_reg.value == value_reg) && (link_reg.idx < pos));

    always_comb
    begin
        value_next = value_reg;
        link_next  = link_reg;
        rank_next  = rank_reg;
        if (ctrl.load)
        begin
            value_next     = (ctrl.start && !head) ? sample_t'(0) : shift_in;
            link_next.value = value_next;
            link_next.idx   = pos;
            rank_next       = rank_t'(0);
        end
        else if (ctrl.step)
        begin
            rank_next = rank_reg + rank_t'(in_win && link_in_win && below);
            link_next = link_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= sample_t'(0);
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        link_reg <= link_next;
        rank_reg <= rank_next;
    end

    assign value    = value_reg;
    assign link_out = link_reg;
    assign rank     = rank_reg;

endmodule

FILE: src/rmf_select.sv
`timescale 1ns / 1ps

module rmf_select (
    input  rmf_pkg::order_t  order,
    input  rmf_pkg::sample_t values [rmf_pkg::WINDOW_MAX],
    input  rmf_pkg::rank_t   ranks  [rmf_pkg::WINDOW_MAX],
    input  logic             in_win [rmf_pkg::WINDOW_MAX],
    output rmf_pkg::sample_t median
);
    import rmf_pkg::*;

    order_t                half;
    order_t                half_lo;
    sample_t               upper;
    sample_t               lower;
    logic [SAMPLE_WIDTH:0] pair_sum;

    assign half    = order >> 1;
    assign half_lo = half - order_t'(1);

    // Ranks are distinct, so at most one cell matches each of the two middle ranks.
    always_comb
    begin
        upper = sample_t'(0);
        lower = sample_t'(0);
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            if (in_win[i] && (order_t'(ranks[i]) == half))
            begin
                upper = upper | values[i];
            end
            if (in_win[i] && (order_t'(ranks[i]) == half_lo))
            begin
                lower = lower | values[i];
            end
        end
    end

    assign pair_sum = {upper[SAMPLE_WIDTH-1], upper} + {lower[SAMPLE_WIDTH-1], lower};
    assign median   = order[0] ? upper : sample_t'(pair_sum[SAMPLE_WIDTH:1]);

endmodule

FILE: src/running_median_filter_top.sv
`timescale 1ns / 1ps

// Channel     Role    Word fields                  Meaning
// sample_ch   sink    sample (s16), start_req (1)  new sample, optional window clear
// median_ch   source  median (s16)                 median of the newest samples
// cfg_we/     write   cfg_wdata (u5)               window order, reset value 16
//
// For each word, the accept edge shifts the window, then a copy of every
// sample travels once round the ring of cells, and the done state registers
// the median. The ring length WINDOW_MAX sets the length of the rotation.
// Reset clears the window to zeros and the order register to 16.
// A result waiting in the output register does not block the next accept; the
// final cycle of a word holds until the output register is free.
module running_median_filter_top (
    input  logic              clk,
    input  logic              rst_n,
    rmf_in_if.sink            sample_ch,
    rmf_out_if.source         median_ch,
    input  logic              cfg_we,
    input  rmf_pkg::order_t   cfg_wdata
);
    import rmf_pkg::*;

    // Sequencer state and the step counter that times the ring rotation.
    state_t  state_reg, state_next;
    idx_t    step_cnt_reg, step_cnt_next;
    order_t  order_reg;
    order_t  order_eff;

    // Output register, which decouples the median channel from the ring.
    logic    out_valid_reg, out_valid_next;
    sample_t median_reg, median_next;

    logic       accept;
    logic       out_free;
    cell_ctrl_t ctrl;
    sample_t    median_sel;

    sample_t values  [WINDOW_MAX];
    link_t   links   [WINDOW_MAX];
    rank_t   ranks   [WINDOW_MAX];
    logic    in_win  [WINDOW_MAX];

    // The order register holds the raw value; out-of-range codes are clamped
    // here so that an order of 0 or 1 acts as 2 and anything above the ring
    // length acts as the full ring.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RESET;
        end
        else if (cfg_we)
        begin
            order_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (order_reg < ORDER_MIN)
        begin
            order_eff = ORDER_MIN;
        end
        else if (order_reg > ORDER_MAX)
        begin
            order_eff = ORDER_MAX;
        end
        else
        begin
            order_eff = order_reg;
        end
    end

    assign sample_ch.ready = (state_reg == ST_IDLE);
    assign accept          = sample_ch.valid && sample_ch.ready;
    assign out_free        = !out_valid_reg || median_ch.ready;

    assign ctrl.load  = accept;
    assign ctrl.start = sample_ch.start_req;
    assign ctrl.step  = (state_reg == ST_RUN);

    // The ring of cells. Cell 0 holds the newest sample; on an accept each other
    // cell takes its neighbour's sample, or zero on a clear; during the run the
    // circulating copies move one cell on per cycle, wrapping from the last to the first.
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        rmf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .pos      (idx_t'(i)),
            .order    (order_eff),
            .shift_in ((i == 0) ? sample_ch.sample : values[(i + WINDOW_MAX - 1) % WINDOW_MAX]),
            .link_in  (links[(i + WINDOW_MAX - 1) % WINDOW_MAX]),
            .value    (values[i]),
            .link_out (links[i]),
            .rank     (ranks[i]),
            .in_win   (in_win[i])
        );
    end

    rmf_select u_select (
        .order  (order_eff),
        .values (values),
        .ranks  (ranks),
        .in_win (in_win),
        .median (median_sel)
    );

    // Sequencer: idle until a word arrives, run the ring for a full turn, then
    // hand the median to the output register as soon as it is free.
    always_comb
    begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        out_valid_next = out_valid_reg;
        median_next    = median_reg;

        if (out_valid_reg && median_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_RUN;
                    step_cnt_next = idx_t'(0);
                end
            end
            ST_RUN:
            begin
                step_cnt_next = step_cnt_reg + idx_t'(1);
                if (step_cnt_reg == idx_t'(WINDOW_MAX - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    median_next    = median_sel;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                step_cnt_next = idx_t'(0);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= idx_t'(0);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
    end

    assign median_ch.valid  = out_valid_reg;
    assign median_ch.median = median_reg;

    // Cells that hold the upper middle rank; exactly one must match once the
    // ring has completed its turn.
    order_t                half_chk;
    logic [WINDOW_MAX-1:0] hit_mid;

    assign half_chk = order_eff >> 1;

    always_comb
    begin
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            hit_mid[i] = in_win[i] && (order_t'(ranks[i]) == half_chk);
        end
    end

    a_run_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN))
        else $error("ring did not start after an accepted word");

    a_idle_counter_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (step_cnt_reg == idx_t'(0)))
        else $error("step counter not at zero while idle");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result appeared without a completed ring turn");

    a_unique_middle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> ($countones(hit_mid) == 1))
        else $error("middle rank not held by exactly one cell");

endmodule

FILE: tb/rmf_median_checker.sv
`timescale 1ns / 1ps

module rmf_median_checker (
    input  logic             clk,
    input  logic             rst_n,
    rmf_in_if                sample_mon,
    rmf_out_if               median_mon,
    input  logic             cfg_we,
    input  rmf_pkg::order_t  cfg_wdata,
    output int               error_count,
    output int               medians_owed
);
    import rmf_pkg::*;

    sample_t history [WINDOW_MAX];
    order_t  order_reg;
    sample_t medians_due [$];

    // Median of the newest entries of a window held newest first.
    function automatic sample_t window_median(input sample_t win [WINDOW_MAX],
                                              input order_t ord);
        sample_t                       sorted_vals [WINDOW_MAX];
        sample_t                       v;
        int                            count;
        int                            j;
        logic signed [SAMPLE_WIDTH:0]  pair_sum;
        count = int'(ord);
        if (count < int'(ORDER_MIN))
            count = int'(ORDER_MIN);
        if (count > WINDOW_MAX)
            count = WINDOW_MAX;
        for (int i = 0; i < count; i++)
        begin
            v = win[i];
            j = i;
            while (j > 0 && sorted_vals[j-1] > v)
            begin
                sorted_vals[j] = sorted_vals[j-1];
                j--;
            end
            sorted_vals[j] = v;
        end
        if (count % 2 == 1)
            return sorted_vals[count/2];
        pair_sum = sorted_vals[count/2-1] + sorted_vals[count/2];
        return pair_sum[SAMPLE_WIDTH:1];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        sample_t due;
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_MAX; i++)
                history[i] = '0;
            order_reg = ORDER_RESET;
            medians_due.delete();
            error_count  <= 0;
            medians_owed <= 0;
        end
        else
        begin
            if (cfg_we)
                order_reg = cfg_wdata;

            // The result leaving now always belongs to an older word than one entering.
            if (median_mon.valid && median_mon.ready)
            begin
                if (medians_due.size() == 0)
                begin
                    $display("%0t: median %0d arrived with no sample waiting",
                             $time, median_mon.median);
                    error_count <= error_count + 1;
                end
                else
                begin
                    due = medians_due.pop_front();
                    if (median_mon.median !== due)
                    begin
                        $display("%0t: median mismatch, expected %0d, actual %0d",
                                 $time, due, median_mon.median);
                        error_count <= error_count + 1;
                    end
                end
            end

            if (sample_mon.valid && sample_mon.ready)
            begin
                if (sample_mon.start_req)
                    for (int i = 0; i < WINDOW_MAX; i++)
                        history[i] = '0;
                for (int i = WINDOW_MAX - 1; i > 0; i--)
                    history[i] = history[i-1];
                history[0] = sample_mon.sample;
                medians_due.push_back(window_median(history, order_reg));
            end

            medians_owed <= medians_due.size();
        end
    end

endmodule

FILE: tb/running_median_filter_top_tb.sv
`timescale 1ns / 1ps

module running_median_filter_top_tb;

    import rmf_pkg::*;

    // Worst case per word is roughly the block's word time, the longest stall at
    // the receiver and a sender gap; the limit is several times that over the run.
    localparam int CYCLE_LIMIT = 500000;
    // Cycles allowed after the last median before the window order is changed.
    localparam int SETTLE      = 20;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 90;

    logic   clk;
    logic   rst_n;
    logic   cfg_we;
    order_t cfg_wdata;

    rmf_in_if  sample_ch ();
    rmf_out_if median_ch ();

    int error_count;
    int medians_owed;
    int cycle_count = 0;
    int rx_mode     = 0;
    int rx_stall    = 0;
    int rx_tick     = 0;
    int gap_max     = 0;
    int burst_left  = 0;

    running_median_filter_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .median_ch (median_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    rmf_median_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_mon   (sample_ch),
        .median_mon   (median_ch),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .error_count  (error_count),
        .medians_owed (medians_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A run that hangs is a failure in its own right.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("running_median_filter_top_tb: errors");
            $finish;
        end
    end

    // The receiver has three habits: always ready, random stalls, and a fixed
    // repeating pattern that drifts against the block's word time so that stalls
    // land on every phase of its work.
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            0:
                median_ch.ready <= 1'b1;
            1:
                if (rx_stall > 0)
                begin
                    rx_stall        <= rx_stall - 1;
                    median_ch.ready <= 1'b0;
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    rx_stall        <= $urandom_range(0, 40);
                    median_ch.ready <= 1'b0;
                end
                else
                    median_ch.ready <= 1'b1;
            default:
                median_ch.ready <= (rx_tick % 7) < 4;
        endcase
    end

    // Offers one word from a falling edge and holds it until it is taken. It
    // returns at the next falling edge with valid still high, so a following
    // word simply replaces the payload without valid dropping.
    task automatic push_sample(input sample_t value, input logic clear);
        sample_ch.valid     <= 1'b1;
        sample_ch.sample    <= value;
        sample_ch.start_req <= clear;
        @(posedge clk);
        while (!(sample_ch.valid && sample_ch.ready))
            @(posedge clk);
        @(negedge clk);
    endtask

    // Bursts of random length, separated by random gaps when gaps are allowed.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    // Stops sending until every median owed has been taken, then lets the
    // block settle. The order register is only ever changed after this.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (medians_owed != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_order(input order_t ord);
        cfg_we    <= 1'b1;
        cfg_wdata <= ord;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Uniform samples, with extremes, small values that force ties,
    // repeats and short walks from the previous sample mixed in.
    function automatic sample_t pick_sample(input sample_t prev);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                return sample_t'($urandom);
            4:
                case ($urandom_range(0, 3))
                    0:       return sample_t'(16'h7FFF);
                    1:       return sample_t'(16'h8000);
                    2:       return sample_t'(0);
                    default: return sample_t'(-1);
                endcase
            5, 6:
                return sample_t'(int'($urandom_range(0, 8)) - 4);
            7:
                return prev;
            default:
                return prev + sample_t'(int'($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    initial
    begin
        sample_t last_sample;
        order_t  ord;
        int      clear_odds;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.sample    = '0;
        sample_ch.start_req = 1'b0;
        median_ch.ready     = 1'b0;
        last_sample         = '0;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words at the reset order of 16: extremes at full scale, the
        // fill phase with zeros still in the window, and a clear in mid-stream.
        push_sample(sample_t'(16'h7FFF), 1'b1);
        push_sample(sample_t'(16'h8000), 1'b0);
        push_sample(sample_t'(16'h7FFF), 1'b0);
        push_sample(sample_t'(16'h8000), 1'b0);
        push_sample(sample_t'(0), 1'b0);
        push_sample(sample_t'(-1), 1'b0);
        push_sample(sample_t'(1), 1'b0);
        push_sample(sample_t'(16'h5555), 1'b0);
        push_sample(sample_t'(16'hAAAA), 1'b0);
        push_sample(sample_t'(-1), 1'b0);
        push_sample(sample_t'(16'h8000), 1'b1);
        push_sample(sample_t'(16'h7FFF), 1'b0);
        drain();

        // An order below the range behaves as two: this exercises the floored
        // mean of the middle pair, including the widest pair of opposite signs
        // and odd negative sums.
        write_order(order_t'(1));
        push_sample(sample_t'(16'h7FFF), 1'b0);
        push_sample(sample_t'(16'h8000), 1'b0);
        push_sample(sample_t'(16'h8000), 1'b0);
        push_sample(sample_t'(16'h7FFF), 1'b0);
        push_sample(sample_t'(16'h7FFF), 1'b0);
        push_sample(sample_t'(-1), 1'b0);
        push_sample(sample_t'(0), 1'b0);
        push_sample(sample_t'(3), 1'b1);
        push_sample(sample_t'(-3), 1'b0);
        push_sample(sample_t'(-4), 1'b0);
        push_sample(sample_t'(-5), 1'b0);
        drain();

        // Random phases, each at its own order with its own sender and
        // receiver habits. Orders zero and 31 and 17 cover both ends of the
        // register beyond the useful range.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       ord = order_t'(2);
                1:       ord = order_t'(3);
                2:       ord = order_t'(0);
                3:       ord = order_t'(31);
                4:       ord = order_t'(17);
                5:       ord = order_t'(16);
                6:       ord = order_t'(15);
                7:       ord = order_t'(9);
                8:       ord = order_t'(4);
                default: ord = order_t'($urandom_range(0, 31));
            endcase
            rx_mode    = phase % 3;
            gap_max    = (phase % 4 == 1) ? 0 : 6;
            clear_odds = (phase % 2 == 1) ? 8 : 60;
            burst_left = 0;
            write_order(ord);

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pace_sender();
                last_sample = pick_sample(last_sample);
                push_sample(last_sample, $urandom_range(0, clear_odds - 1) == 0);
            end
            drain();
        end

        if (error_count == 0 && medians_owed == 0)
            $display("running_median_filter_top_tb: clean");
        else
            $display("running_median_filter_top_tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
src/rmf_pkg.sv
src/rmf_if.sv
src/rmf_cell.sv
src/rmf_select.sv
src/running_median_filter_top.sv
tb/rmf_median_checker.sv
tb/running_median_filter_top_tb.sv
